/* hdl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned SPQ_CAPACITY = 16;
  localparam int unsigned ValW = 32;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP
  } cell_op_e;

  typedef struct packed {
    logic [1:0]             command;
    logic signed [ValW-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [ValW-1:0] popped_value;
    logic signed [ValW-1:0] head_value;
    logic                   is_empty;
    logic [1:0]             status;
  } out_t;

  // Broadcast from the control to every cell of the row.
  typedef struct packed {
    cell_op_e               op;
    logic signed [ValW-1:0] value;
  } cell_ctrl_t;

endpackage

/* hdl/spq_cell.sv */
// One storage cell of the sorted row: compare, hold, insert or shift.
module spq_cell (
  input  logic                           clk_i,
  input  spq_pkg::cell_ctrl_t            ctrl_i,
  input  logic                           occupied_i,
  input  logic                           left_keep_i,
  input  logic signed [spq_pkg::ValW-1:0] left_value_i,
  input  logic signed [spq_pkg::ValW-1:0] right_value_i,
  output logic                           keep_o,
  output logic signed [spq_pkg::ValW-1:0] value_o
);
  import spq_pkg::*;

  logic signed [ValW-1:0] value_q, value_d;

  // Stays put on a push when it holds a strictly greater value.
  assign keep_o  = occupied_i && (value_q > ctrl_i.value);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      CELL_PUSH: begin
        if (!keep_o) begin
          value_d = left_keep_i ? ctrl_i.value : left_value_i;
        end
      end
      CELL_POP:  value_d = right_value_i;
      CELL_HOLD: value_d = value_q;
      default:   value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

/* hdl/sorted_priority_queue.sv */
// Top level of the sorted priority queue: command decode, cell row, result register.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one command
//   beat: push a signed value, pop the head, or clear. Output channel
//   (out_valid_o / out_stall_i / out_data_o) returns exactly one result beat
//   per command: popped value, new head value, empty flag and status.
//   The result is registered and appears in the cycle after the command beat is taken.
//   Throughput: one command per cycle unless stalled; every cell of the row
//   compares and shifts in the same cycle, so queue depth does not set the rate.
//   The single result register is the only buffer: while a result waits
//   under out_stall_i, in_stall_o is raised and no new command is taken, and
//   the waiting result holds steady.
//   Reset empties the queue (entry count to zero) and drops any pending
//   result; cell contents are left as they are and count as empty.
//   A push into a full queue is dropped, a pop on an empty queue is ignored,
//   each with its status code; command code 3 does nothing.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::SPQ_CAPACITY
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  spq_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output spq_pkg::out_t  out_data_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]        count_q, count_d;
  logic                   out_valid_q;
  out_t                   out_q, out_d;
  logic                   accept;
  cell_ctrl_t             ctrl;
  logic                   full, empty;

  logic [CAPACITY-1:0]    occupied;
  logic [CAPACITY-1:0]    keep;
  logic signed [ValW-1:0] cell_value [CAPACITY];

  // Hold the command while an unclaimed result sits in the register.
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign full  = (count_q == CntW'(CAPACITY));
  assign empty = (count_q == '0);

  // Cell row: each cell sees its left and right neighbour.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);
    logic                   left_keep;
    logic signed [ValW-1:0] left_value, right_value;

    assign occupied[i] = Idx < count_q;

    if (i == 0) begin : g_first
      assign left_keep  = 1'b1;
      assign left_value = ctrl.value;
    end else begin : g_inner
      assign left_keep  = keep[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_body
      assign right_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (occupied[i]),
      .left_keep_i   (left_keep),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .keep_o        (keep[i]),
      .value_o       (cell_value[i])
    );
  end

  // Decode the command beat into a row operation, the new count and the result.
  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.value = in_data_i.value;
    count_d    = count_q;
    out_d      = out_q;
    if (accept) begin
      out_d.popped_value = '0;
      out_d.status       = ST_OK;
      out_d.head_value   = empty ? '0 : cell_value[0];
      case (in_data_i.command)
        CMD_PUSH: begin
          if (full) begin
            out_d.status = ST_PUSH_FULL;
          end else begin
            ctrl.op          = CELL_PUSH;
            count_d          = count_q + CntW'(1);
            out_d.head_value = keep[0] ? cell_value[0] : in_data_i.value;
          end
        end
        CMD_POP: begin
          if (empty) begin
            out_d.status = ST_POP_EMPTY;
          end else begin
            ctrl.op            = CELL_POP;
            count_d            = count_q - CntW'(1);
            out_d.popped_value = cell_value[0];
            // Advance: the second entry becomes the head, if there is one.
            out_d.head_value   = occupied[1] ? cell_value[1] : '0;
          end
        end
        CMD_CLEAR: begin
          count_d          = '0;
          out_d.head_value = '0;
        end
        default: begin
          ctrl.op = CELL_HOLD;
        end
      endcase
      out_d.is_empty = (count_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the sorted priority queue: directed and random beats.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam time         ClkPeriod  = 10ns;
  localparam int unsigned ResetTicks = 6;
  localparam int unsigned Capacity   = SPQ_CAPACITY;
  localparam int unsigned PhaseBeats = 400;
  localparam int unsigned BlockBeats = 30;
  localparam int unsigned ReportMax  = 10;
  // Command code 3 has no member in the package; the block treats it as a no-op.
  localparam logic [1:0]  CMD_NOP    = 2'd3;

  localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};

  // Reference ordering of the queue plus the results still owed by the block.
  class spq_scoreboard;
    logic signed [ValW-1:0] ranked[$];
    out_t                   owed[$];
    int unsigned            errors;

    function void note_command(in_t beat);
      out_t                   res;
      logic signed [ValW-1:0] v;
      int                     pos;
      res = '0;
      v   = beat.value;
      pos = 0;
      case (beat.command)
        CMD_PUSH: begin
          if (ranked.size() >= Capacity) begin
            res.status = ST_PUSH_FULL;
          end else begin
            // Go ahead of every entry that is not strictly greater.
            while (pos < ranked.size() && ranked[pos] > v) pos++;
            ranked.insert(pos, v);
          end
        end
        CMD_POP: begin
          if (ranked.size() == 0) begin
            res.status = ST_POP_EMPTY;
          end else begin
            res.popped_value = ranked.pop_front();
          end
        end
        CMD_CLEAR: begin
          ranked.delete();
        end
        default: ;
      endcase
      res.is_empty   = (ranked.size() == 0);
      res.head_value = (ranked.size() == 0) ? '0 : ranked[0];
      owed.push_back(res);
    endfunction

    function void flag(string what, logic [ValW-1:0] want, logic [ValW-1:0] got);
      errors++;
      if (errors <= ReportMax)
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= ReportMax)
          $display("%0t: result with nothing owed: %0h", $realtime, got);
        return;
      end
      want = owed.pop_front();
      if (got.popped_value !== want.popped_value)
        flag("popped_value", want.popped_value, got.popped_value);
      if (got.head_value !== want.head_value)
        flag("head_value", want.head_value, got.head_value);
      if (got.is_empty !== want.is_empty)
        flag("is_empty", ValW'(want.is_empty), ValW'(got.is_empty));
      if (got.status !== want.status)
        flag("status", ValW'(want.status), ValW'(got.status));
    endfunction

    function int unsigned outstanding();
      return owed.size();
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  spq_scoreboard board = new();

  sorted_priority_queue dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Receiver back-pressure: redraw the stall every cycle, blind to out_valid_o.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watch both channels at the rising edge. Check the result before noting the
  // new command: a result never belongs to the command taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_result(out_data_o);
      if (in_valid_i && !in_stall_o) board.note_command(in_data_i);
    end
  end

  // Hard stop for a hung handshake; far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic in_t make_beat(logic [1:0] cmd, logic signed [ValW-1:0] v);
    in_t b;
    b.command = cmd;
    b.value   = v;
    return b;
  endfunction

  // Spread values over the whole range, a narrow band (so ties are common)
  // and the extremes.
  function automatic logic signed [ValW-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return $urandom;
    if (sel < 75) return $signed($urandom_range(8)) - 4;
    case ($urandom_range(3))
      0:       return ValMax;
      1:       return ValMin;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Called at a falling edge; return at the falling edge after the beat is taken.
  task automatic send_beat(in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Lower valid and hold off until every owed result has been returned.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (board.outstanding() != 0);
  endtask

  // Random commands in blocks; each block leans towards push or pop so the
  // queue swings between empty and full. Clears and no-ops stay rare.
  task automatic random_phase(int unsigned beats);
    int unsigned push_pct;
    int unsigned roll;
    logic [1:0]  cmd;
    push_pct = 50;
    for (int unsigned n = 0; n < beats; n++) begin
      if (n % BlockBeats == 0) begin
        case ($urandom_range(3))
          0:       push_pct = 20;
          1:       push_pct = 50;
          2:       push_pct = 70;
          default: push_pct = 92;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 3)                 cmd = CMD_CLEAR;
      else if (roll < 5)            cmd = CMD_NOP;
      else if (roll < 5 + push_pct) cmd = CMD_PUSH;
      else                          cmd = CMD_POP;
      send_beat(make_beat(cmd, pick_value()));
    end
  endtask

  initial begin
    repeat (ResetTicks) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty-queue corner cases first.
    send_beat(make_beat(CMD_POP, '0));
    send_beat(make_beat(CMD_NOP, ValMax));
    send_beat(make_beat(CMD_CLEAR, ValMin));
    // Fill to capacity with extremes, ties and alternating bit patterns.
    send_beat(make_beat(CMD_PUSH, ValMax));
    send_beat(make_beat(CMD_PUSH, ValMin));
    send_beat(make_beat(CMD_PUSH, 32'sd0));
    send_beat(make_beat(CMD_PUSH, -32'sd1));
    send_beat(make_beat(CMD_PUSH, 32'sd5));
    send_beat(make_beat(CMD_PUSH, 32'sd5));
    send_beat(make_beat(CMD_PUSH, 32'sd5));
    send_beat(make_beat(CMD_PUSH, 32'sd1));
    send_beat(make_beat(CMD_PUSH, 32'h4000_0000));
    send_beat(make_beat(CMD_PUSH, 32'hC000_0000));
    send_beat(make_beat(CMD_PUSH, 32'h5555_5555));
    send_beat(make_beat(CMD_PUSH, 32'hAAAA_AAAA));
    send_beat(make_beat(CMD_PUSH, 32'sd7));
    send_beat(make_beat(CMD_PUSH, -32'sd7));
    send_beat(make_beat(CMD_PUSH, ValMax));
    send_beat(make_beat(CMD_PUSH, ValMin));
    // Full-queue corner cases, then unwind.
    send_beat(make_beat(CMD_PUSH, 32'sd3));
    send_beat(make_beat(CMD_NOP, 32'sd3));
    send_beat(make_beat(CMD_POP, '0));
    send_beat(make_beat(CMD_POP, '0));
    send_beat(make_beat(CMD_CLEAR, '0));
    drain();

    // Light sender gaps against a heavily stalling receiver.
    send_idle_pct  = 16;
    recv_stall_pct = 80;
    random_phase(PhaseBeats);
    drain();

    // Swap the roles: bursty sender, mostly ready receiver.
    send_idle_pct  = 80;
    recv_stall_pct = 16;
    random_phase(PhaseBeats);
    drain();

    // Full rate both ways.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_phase(PhaseBeats);
    drain();

    // Allow for a stray late result before judging.
    repeat (4) @(negedge clk_i);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
